// ===== sv/tgc_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch gesture classifier package
// Shared payload types, gesture and register codes, fixed timing constants.
// ----------------------------------------------------------------------------
package tgc_pkg;

  typedef logic [15:0] level_t;
  typedef logic [31:0] usec_t;
  typedef logic [2:0]  code_t;

  localparam int unsigned CFG_DW = 32;
  localparam int unsigned CFG_IW = 3;

  typedef enum logic [2:0] {
    G_IDLE     = 3'd0,
    G_PLUCK    = 3'd1,
    G_SCRAPE   = 3'd2,
    G_BOW      = 3'd3,
    G_HARMONIC = 3'd4,
    G_VIBRATO  = 3'd5,
    G_TREMOLO  = 3'd6,
    G_MUTED    = 3'd7
  } gesture_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_CONTACT_THR   = 3'd0,
    CFG_HOLDOFF       = 3'd1,
    CFG_SCRAPE_WIN    = 3'd2,
    CFG_TREM_STEP     = 3'd3,
    CFG_TREM_PERIOD   = 3'd4,
    CFG_WOBBLE_GOAL   = 3'd5,
    CFG_VIB_DEPTH     = 3'd6,
    CFG_MUTE_THR      = 3'd7
  } cfg_idx_e;

  localparam usec_t  GRACE_US           = 32'd50000;
  localparam level_t HARMONIC_PEAK_LOW  = 16'd8192;
  localparam level_t HARMONIC_PEAK_HIGH = 16'd24576;
  localparam level_t HARMONIC_FLATNESS  = 16'd1024;
  localparam usec_t  HARM_DWELL_US      = 32'd200000;
  localparam usec_t  SHORT_TOUCH_US     = 32'd30000;

endpackage

// ===== sv/tgc_if.sv =====
// ----------------------------------------------------------------------------
// Touch gesture classifier channels
// Valid/ready channels for pressure samples and gesture codes.
// ----------------------------------------------------------------------------
interface tgc_sample_if import tgc_pkg::*; ();
  logic   valid;
  logic   ready;
  level_t sample_value;
  usec_t  sample_time_us;

  modport source (output valid, output sample_value, output sample_time_us, input ready);
  modport sink   (input valid, input sample_value, input sample_time_us, output ready);
endinterface

interface tgc_gesture_if import tgc_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t gesture_code;

  modport source (output valid, output gesture_code, input ready);
  modport sink   (input valid, input gesture_code, output ready);
endinterface

// ===== sv/touch_gesture_classifier.sv =====
// ----------------------------------------------------------------------------
// Touch gesture classifier
// Classifies timestamped pressure samples into one gesture code per word.
// ----------------------------------------------------------------------------
//  channel    dir  word
//  sample_i   in   sample_value[15:0], sample_time_us[31:0]
//  gesture_o  out  gesture_code[2:0]
//  cfg        in   cfg_we_i, cfg_idx_i[2:0], cfg_wdata_i[31:0]
//
//  One word per cycle sustained while gesture_o is ready; a word passes the
//  input register, then classify and state update into the result register.
//  Reset clears all contact state, configuration and both valid flags.
//  A stalled result holds the pipe; the input register still refills when
//  the result is taken in the same cycle.
// ----------------------------------------------------------------------------
module touch_gesture_classifier import tgc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  tgc_sample_if.sink         sample_i,
  tgc_gesture_if.source      gesture_o,
  input  logic               cfg_we_i,
  input  logic [CFG_IW-1:0]  cfg_idx_i,
  input  logic [CFG_DW-1:0]  cfg_wdata_i
);

  typedef enum logic [1:0] {
    PH_RELEASED   = 2'd0,
    PH_ATTACKING  = 2'd1,
    PH_SUSTAINING = 2'd2
  } phase_e;

  // configuration
  logic [31:0] contact_thr_q, holdoff_q, scrape_win_q, trem_period_q, mute_thr_q;
  level_t      trem_step_q, vib_depth_q;
  logic [7:0]  wobble_goal_q;

  // input register
  logic   in_vld_q;
  level_t v_q;
  usec_t  t_q;

  // result register
  logic     out_vld_q;
  gesture_e gesture_q, gesture_d;

  // contact state
  logic       in_contact_q, in_contact_d;
  phase_e     phase_q, phase_d;
  usec_t      start_q, start_d, last_rev_q, last_rev_d, last_onset_q, last_onset_d;
  level_t     peak_q, peak_d, lo_q, lo_d, hi_q, hi_d, prev_q;
  logic [7:0] rev_cnt_q, rev_cnt_d;
  logic       dir_up_q, dir_up_d, harm_q, harm_d, mod_q, mod_d, mute_q, mute_d;

  logic   adv, onset, c_on, rising, rev_hit, band;
  phase_e ph0;
  level_t step, depth;
  usec_t  dt_onset;

  assign adv             = in_vld_q & (~out_vld_q | gesture_o.ready);
  assign sample_i.ready  = ~in_vld_q | adv;
  assign gesture_o.valid = out_vld_q;
  assign gesture_o.gesture_code = code_t'(gesture_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contact_thr_q <= '0;
      holdoff_q     <= '0;
      scrape_win_q  <= '0;
      trem_step_q   <= '0;
      trem_period_q <= '0;
      wobble_goal_q <= '0;
      vib_depth_q   <= '0;
      mute_thr_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CONTACT_THR: contact_thr_q <= cfg_wdata_i;
        CFG_HOLDOFF:     holdoff_q     <= cfg_wdata_i;
        CFG_SCRAPE_WIN:  scrape_win_q  <= cfg_wdata_i;
        CFG_TREM_STEP:   trem_step_q   <= cfg_wdata_i[15:0];
        CFG_TREM_PERIOD: trem_period_q <= cfg_wdata_i;
        CFG_WOBBLE_GOAL: wobble_goal_q <= cfg_wdata_i[7:0];
        CFG_VIB_DEPTH:   vib_depth_q   <= cfg_wdata_i[15:0];
        CFG_MUTE_THR:    mute_thr_q    <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (sample_i.ready) begin
      in_vld_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.ready && sample_i.valid) begin
      v_q <= sample_i.sample_value;
      t_q <= sample_i.sample_time_us;
    end
  end

  always_comb begin
    c_on         = in_contact_q | (v_q >= contact_thr_q[15:0]);
    in_contact_d = c_on & ~(v_q <= contact_thr_q[31:16]);
    onset        = in_contact_d & ~in_contact_q;

    start_d      = onset ? t_q : start_q;
    peak_d       = onset ? v_q : peak_q;
    lo_d         = onset ? v_q : lo_q;
    hi_d         = onset ? v_q : hi_q;
    rev_cnt_d    = onset ? 8'd0 : rev_cnt_q;
    last_rev_d   = onset ? t_q : last_rev_q;
    dir_up_d     = onset ? 1'b1 : dir_up_q;
    harm_d       = onset ? 1'b0 : harm_q;
    mod_d        = onset ? 1'b0 : mod_q;
    mute_d       = onset ? 1'b0 : mute_q;
    ph0          = onset ? PH_ATTACKING : phase_q;
    phase_d      = ph0;
    last_onset_d = last_onset_q;
    gesture_d    = G_IDLE;

    if (in_contact_d) begin
      if (v_q > peak_d) peak_d = v_q;
      if (v_q < lo_d)   lo_d   = v_q;
      if (v_q > hi_d)   hi_d   = v_q;
      if (ph0 == PH_ATTACKING && (t_q - start_d) > GRACE_US) phase_d = PH_SUSTAINING;
    end

    rising  = v_q >= prev_q;
    step    = rising ? v_q - prev_q : prev_q - v_q;
    rev_hit = (step >= trem_step_q) && (phase_d == PH_SUSTAINING) && (rising != dir_up_d);
    if (rev_hit) begin
      if ((t_q - last_rev_d) <= trem_period_q) begin
        if (rev_cnt_d != 8'hFF) rev_cnt_d = rev_cnt_d + 8'd1;
      end else begin
        rev_cnt_d = 8'd1;
      end
      last_rev_d = t_q;
      dir_up_d   = rising;
    end

    depth    = hi_d - lo_d;
    band     = (peak_d >= HARMONIC_PEAK_LOW) && (peak_d <= HARMONIC_PEAK_HIGH);
    dt_onset = t_q - last_onset_q;

    priority if (onset) begin
      if (dt_onset >= holdoff_q) begin
        gesture_d    = (dt_onset < scrape_win_q) ? G_SCRAPE : G_PLUCK;
        last_onset_d = t_q;
      end
    end else if (in_contact_d) begin
      priority if (!harm_q && band && depth <= HARMONIC_FLATNESS &&
                   (t_q - start_q) > HARM_DWELL_US) begin
        harm_d    = 1'b1;
        gesture_d = G_HARMONIC;
      end else if (!mod_q && rev_cnt_d >= wobble_goal_q) begin
        mod_d     = 1'b1;
        gesture_d = (depth >= vib_depth_q) ? G_VIBRATO : G_TREMOLO;
      end else begin
        gesture_d = G_BOW;
      end
      if (peak_d <= mute_thr_q[15:0] && v_q <= mute_thr_q[31:16]) mute_d = 1'b1;
    end else if (in_contact_q) begin
      phase_d = PH_RELEASED;
      if ((t_q - start_q) <= SHORT_TOUCH_US || mute_q) gesture_d = G_MUTED;
    end else begin
      gesture_d = G_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q    <= 1'b0;
      gesture_q    <= G_IDLE;
      in_contact_q <= 1'b0;
      phase_q      <= PH_RELEASED;
      start_q      <= '0;
      peak_q       <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      rev_cnt_q    <= '0;
      last_rev_q   <= '0;
      dir_up_q     <= 1'b0;
      harm_q       <= 1'b0;
      mod_q        <= 1'b0;
      mute_q       <= 1'b0;
      prev_q       <= '0;
      last_onset_q <= '0;
    end else begin
      if (gesture_o.ready) out_vld_q <= 1'b0;
      if (adv) begin
        out_vld_q    <= 1'b1;
        gesture_q    <= gesture_d;
        in_contact_q <= in_contact_d;
        phase_q      <= phase_d;
        start_q      <= start_d;
        peak_q       <= peak_d;
        lo_q         <= lo_d;
        hi_q         <= hi_d;
        rev_cnt_q    <= rev_cnt_d;
        last_rev_q   <= last_rev_d;
        dir_up_q     <= dir_up_d;
        harm_q       <= harm_d;
        mod_q        <= mod_d;
        mute_q       <= mute_d;
        prev_q       <= v_q;
        last_onset_q <= last_onset_d;
      end
    end
  end

  a_phase_tracks_contact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_contact_q == (phase_q != PH_RELEASED))
    else $error("contact phase disagrees with contact flag");

  a_onset_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && onset |=> (gesture_q == G_IDLE || gesture_q == G_PLUCK || gesture_q == G_SCRAPE))
    else $error("onset gave a sustain or release gesture");

  a_release_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_contact_q && !in_contact_d |=> (gesture_q == G_IDLE || gesture_q == G_MUTED))
    else $error("release gave a contact gesture");

endmodule

// ===== bench/touch_gesture_classifier_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch gesture classifier testbench
// Streams timestamped pressure words through the classifier under several
// register settings, predicts each gesture code in a cycle-free model of the
// contact tracker and compares every returned word in order. Both channels
// idle at random, the gesture side holds off for a long stretch once.
// ----------------------------------------------------------------------------
module touch_gesture_classifier_tb import tgc_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 100000;

  typedef enum logic [1:0] {
    PH_RELEASED   = 2'd0,
    PH_ATTACKING  = 2'd1,
    PH_SUSTAINING = 2'd2
  } touch_phase_e;

  typedef struct packed {
    level_t value;
    usec_t  stamp;
  } sample_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_IW-1:0] cfg_idx_i = '0;
  logic [CFG_DW-1:0] cfg_wdata_i = '0;

  tgc_sample_if  sample_ch ();
  tgc_gesture_if gesture_ch ();

  touch_gesture_classifier u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_ch),
    .gesture_o   (gesture_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // register mirror
  usec_t      cfg_contact_thr = '0;
  usec_t      cfg_holdoff = '0;
  usec_t      cfg_scrape_win = '0;
  level_t     cfg_trem_step = '0;
  usec_t      cfg_trem_period = '0;
  logic [7:0] cfg_wobble_goal = '0;
  level_t     cfg_vib_depth = '0;
  usec_t      cfg_mute_thr = '0;

  // contact tracker state
  logic         touching = 1'b0;
  touch_phase_e touch_phase = PH_RELEASED;
  usec_t        touch_start = '0;
  level_t       peak = '0;
  level_t       wob_low = '0;
  level_t       wob_high = '0;
  logic [7:0]   rev_count = '0;
  usec_t        last_rev_time = '0;
  logic         dir_rising = 1'b0;
  logic         harmonic_done = 1'b0;
  logic         modulation_done = 1'b0;
  logic         mute_armed = 1'b0;
  level_t       prev_level = '0;
  usec_t        last_onset = '0;

  sample_word_t pending_samples[$];
  gesture_e     expected_codes[$];
  int unsigned  items_queued = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  sink_hold_left = 0;
  logic         steady = 1'b0;
  usec_t        now_us = '0;

  function automatic gesture_e classify_sample(level_t v, usec_t t);
    level_t   on_lvl, off_lvl, move, depth;
    usec_t    since_start, since_onset, since_rev;
    logic     was, onset, rising, band;
    gesture_e g;
    on_lvl  = cfg_contact_thr[15:0];
    off_lvl = cfg_contact_thr[31:16];
    was = touching;
    g = G_IDLE;
    if (!touching && v >= on_lvl) touching = 1'b1;
    if (touching && v <= off_lvl) touching = 1'b0;
    onset = touching && !was;
    if (onset) begin
      touch_start = t;
      peak = v;
      wob_low = v;
      wob_high = v;
      rev_count = '0;
      last_rev_time = t;
      dir_rising = 1'b1;
      harmonic_done = 1'b0;
      modulation_done = 1'b0;
      mute_armed = 1'b0;
      touch_phase = PH_ATTACKING;
    end
    if (touching) begin
      if (v > peak) peak = v;
      if (v < wob_low) wob_low = v;
      if (v > wob_high) wob_high = v;
      since_start = t - touch_start;
      if (touch_phase == PH_ATTACKING && since_start > GRACE_US) touch_phase = PH_SUSTAINING;
    end
    rising = v >= prev_level;
    move = rising ? level_t'(v - prev_level) : level_t'(prev_level - v);
    if (move >= cfg_trem_step && touch_phase == PH_SUSTAINING && rising != dir_rising) begin
      since_rev = t - last_rev_time;
      if (since_rev <= cfg_trem_period) begin
        if (rev_count != 8'd255) rev_count = rev_count + 8'd1;
      end else begin
        rev_count = 8'd1;
      end
      last_rev_time = t;
      dir_rising = rising;
    end
    prev_level = v;
    if (onset) begin
      since_onset = t - last_onset;
      if (since_onset >= cfg_holdoff) begin
        g = (since_onset < cfg_scrape_win) ? G_SCRAPE : G_PLUCK;
        last_onset = t;
      end
    end else if (touching) begin
      depth = wob_high - wob_low;
      band = peak >= HARMONIC_PEAK_LOW && peak <= HARMONIC_PEAK_HIGH;
      since_start = t - touch_start;
      if (!harmonic_done && band && depth <= HARMONIC_FLATNESS &&
          since_start > HARM_DWELL_US) begin
        harmonic_done = 1'b1;
        g = G_HARMONIC;
      end else if (!modulation_done && rev_count >= cfg_wobble_goal) begin
        modulation_done = 1'b1;
        g = (depth >= cfg_vib_depth) ? G_VIBRATO : G_TREMOLO;
      end else begin
        g = G_BOW;
      end
      if (peak <= cfg_mute_thr[15:0] && v <= cfg_mute_thr[31:16]) mute_armed = 1'b1;
    end else if (was) begin
      touch_phase = PH_RELEASED;
      since_start = t - touch_start;
      if (since_start <= SHORT_TOUCH_US || mute_armed) g = G_MUTED;
    end
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : sample_driver
    sample_word_t word;
    if (!rst_ni) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready)
        expected_codes.push_back(classify_sample(sample_ch.sample_value,
                                                 sample_ch.sample_time_us));
      if (!sample_ch.valid || sample_ch.ready) begin
        if (pending_samples.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
          word = pending_samples.pop_front();
          sample_ch.valid          <= 1'b1;
          sample_ch.sample_value   <= word.value;
          sample_ch.sample_time_us <= word.stamp;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : gesture_monitor
    gesture_e want;
    if (!rst_ni) begin
      gesture_ch.ready <= 1'b0;
    end else begin
      if (gesture_ch.valid && gesture_ch.ready) begin
        if (expected_codes.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected gesture word %0d", gesture_ch.gesture_code);
          mismatch_count++;
        end else begin
          want = expected_codes.pop_front();
          if (gesture_ch.gesture_code !== want) begin
            if (mismatch_count < 10)
              $display("gesture_code mismatch: expected %0d actual %0d",
                       want, gesture_ch.gesture_code);
            mismatch_count++;
          end
        end
      end
      gesture_ch.ready <= (sink_hold_left == 0) && (steady || $urandom_range(99) >= 20);
    end
  end

  always @(posedge clk_i) begin
    if (sink_hold_left != 0) sink_hold_left <= sink_hold_left - 1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_CONTACT_THR: cfg_contact_thr = data;
      CFG_HOLDOFF:     cfg_holdoff = data;
      CFG_SCRAPE_WIN:  cfg_scrape_win = data;
      CFG_TREM_STEP:   cfg_trem_step = data[15:0];
      CFG_TREM_PERIOD: cfg_trem_period = data;
      CFG_WOBBLE_GOAL: cfg_wobble_goal = data[7:0];
      CFG_VIB_DEPTH:   cfg_vib_depth = data[15:0];
      CFG_MUTE_THR:    cfg_mute_thr = data;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all_regs(logic [31:0] thr, logic [31:0] holdoff, logic [31:0] scrape,
                                logic [31:0] trem_step, logic [31:0] trem_period,
                                logic [31:0] goal, logic [31:0] vib, logic [31:0] mute);
    write_reg(CFG_CONTACT_THR, thr);
    write_reg(CFG_HOLDOFF, holdoff);
    write_reg(CFG_SCRAPE_WIN, scrape);
    write_reg(CFG_TREM_STEP, trem_step);
    write_reg(CFG_TREM_PERIOD, trem_period);
    write_reg(CFG_WOBBLE_GOAL, goal);
    write_reg(CFG_VIB_DEPTH, vib);
    write_reg(CFG_MUTE_THR, mute);
    end_writes();
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || sample_ch.valid || expected_codes.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic push_sample(int value, usec_t stamp);
    sample_word_t word;
    if (value < 0) value = 0;
    if (value > 65535) value = 65535;
    word.value = level_t'(value);
    word.stamp = stamp;
    pending_samples.push_back(word);
    items_queued++;
  endtask

  // idle word, onset, alternating contact words, release
  task automatic push_touch(int base, int wobble, int count, int unsigned dt_max);
    int on_lvl, off_lvl, v;
    on_lvl  = cfg_contact_thr[15:0];
    off_lvl = cfg_contact_thr[31:16];
    now_us += ($urandom_range(3) == 0) ? $urandom_range(30000) : $urandom_range(300000);
    push_sample($urandom_range(off_lvl), now_us);
    now_us += $urandom_range(dt_max, dt_max / 2);
    push_sample((base > on_lvl) ? base : on_lvl, now_us);
    for (int i = 0; i < count; i++) begin
      v = base + ((i % 2 != 0) ? wobble : -wobble) + int'($urandom_range(wobble / 8));
      if (v <= off_lvl) v = off_lvl + 1;
      now_us += $urandom_range(dt_max, dt_max / 2);
      push_sample(v, now_us);
    end
    now_us += $urandom_range(dt_max, dt_max / 2);
    push_sample($urandom_range(off_lvl), now_us);
  endtask

  task automatic push_random_touches(int unsigned target);
    int unsigned stop_at;
    stop_at = items_queued + target;
    while (items_queued < stop_at) begin
      case ($urandom_range(9))
        0: repeat ($urandom_range(5, 1)) push_sample($urandom_range(65535), $urandom());
        1: push_touch($urandom_range(65535), $urandom_range(3000), $urandom_range(2), 30000);
        2: push_touch($urandom_range(24576, 8192), $urandom_range(400),
                      $urandom_range(35, 20), 12000);
        3: now_us = $urandom();
        default: push_touch($urandom_range(50000, 1100), $urandom_range(6000),
                            $urandom_range(25, 3), 25000);
      endcase
    end
  endtask

  initial begin : stimulus
    usec_t base_t;
    sample_ch.valid          = 1'b0;
    sample_ch.sample_value   = '0;
    sample_ch.sample_time_us = '0;
    gesture_ch.ready         = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: zero thresholds, zero holdoff and goal
    push_sample(0, 32'h0000_0000);
    push_sample(65535, 32'hFFFF_FFFF);
    push_sample(1, 32'h0000_0001);
    push_sample(32768, 32'h8000_0000);
    push_sample(0, 32'h8000_0001);
    push_sample(16'h5555, 32'h5555_5555);
    push_sample(16'hAAAA, 32'hAAAA_AAAA);
    push_sample(0, 32'hAAAA_AAAB);
    wait_drained();

    write_all_regs({16'd1000, 16'd2000}, 20000, 100000, 200, 30000, 1, 3000,
                   {16'd1500, 16'd4000});
    base_t = 32'd1000000;
    push_sample(500, base_t);
    push_sample(3000, base_t + 100000);
    push_sample(500, base_t + 110000);
    push_sample(3000, base_t + 120000);
    push_sample(9000, base_t + 130000);
    push_sample(3000, base_t + 190000);
    push_sample(500, base_t + 200000);
    push_sample(3000, base_t + 205000);
    push_sample(500, base_t + 210000);
    push_sample(3000, base_t + 215000);
    push_sample(3200, base_t + 270000);
    push_sample(3000, base_t + 280000);
    push_sample(1400, base_t + 290000);
    push_sample(500, base_t + 300000);
    push_sample(16000, base_t + 400000);
    push_sample(16100, base_t + 500000);
    push_sample(16050, base_t + 650000);
    push_sample(16000, base_t + 660000);
    push_sample(0, base_t + 670000);
    push_sample(65535, base_t + 680000);
    push_sample(0, base_t + 690000);
    wait_drained();

    // hold the gesture side off while the sender keeps offering words
    write_reg(CFG_WOBBLE_GOAL, 4);
    end_writes();
    now_us = base_t + 1000000;
    sink_hold_left <= 400;
    push_random_touches(200);
    wait_drained();

    write_all_regs({16'd200, 16'd300}, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 16'hFFFF,
                   32'hFFFF_FFFF);
    now_us = 32'hFFF8_0000;
    steady <= 1'b1;
    push_random_touches(150);
    wait_drained();
    steady <= 1'b0;

    // long contact to saturate the reversal count
    write_all_regs({16'd1000, 16'd2000}, 20000, 100000, 0, 32'hFFFF_FFFF, 255, 0,
                   {16'd1500, 16'd4000});
    push_touch(30000, 1000, 320, 2000);
    push_random_touches(20);
    wait_drained();

    write_all_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_sample(65535, now_us);
    repeat (20) push_sample($urandom_range(65535), $urandom());
    push_sample(65535, now_us + 5);
    wait_drained();

    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0 && expected_codes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
